// ===== design/ophist_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the overlapping pattern histogram unit.
// No dependencies; every design file but ophist_ram imports this package.

package ophist_pkg;

    localparam int MAX_BLOCK_LENGTH    = 10;
    localparam int MAX_SEQUENCE_LENGTH = 1048576;

    localparam int M_W      = 4;   // block_length register width
    localparam int IDX_W    = 11;  // pattern_index field width
    localparam int COUNT_W  = 21;  // pattern_count field width
    localparam int SHORT_AW = MAX_BLOCK_LENGTH;
    localparam int LONG_AW  = MAX_BLOCK_LENGTH + 1;
    localparam int SHORT_DEPTH = 1 << SHORT_AW;
    localparam int LONG_DEPTH  = 1 << LONG_AW;
    localparam int SEQ_W    = $clog2(MAX_SEQUENCE_LENGTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT        = '1;
    localparam logic [M_W-1:0]     M_MAX              = M_W'(MAX_BLOCK_LENGTH);
    localparam logic [M_W-1:0]     BLOCK_LENGTH_RESET = M_W'(10);
    localparam logic [SEQ_W-1:0]   SEQ_LIMIT          = SEQ_W'(MAX_SEQUENCE_LENGTH);
    localparam logic [LONG_AW-1:0] CLEAR_LAST         = LONG_AW'(LONG_DEPTH - 1);

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_WRAP_RD,
        ST_WRAP_WR,
        ST_READ_RD,
        ST_READ_OUT
    } back_state_t;

    // One classified item, as handed from the front part to the back part.
    typedef struct packed
    {
        op_t                  kind;
        logic                 clear_req;
        logic                 long_en;
        logic                 short_en;
        logic                 wrap_en;
        logic [LONG_AW-1:0]   long_idx;
        logic [SHORT_AW-1:0]  short_idx;
        logic [M_W-1:0]       m;
        logic [SHORT_AW-1:0]  head;
        logic [SHORT_AW-1:0]  recent;
        logic                 rd_table;
        logic [IDX_W-1:0]     rd_idx;
        logic                 rd_ok;
        logic                 done;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed
    {
        logic q_full;
        logic clearing;
    } stall_t;

    // Mask of the n low bits, n from 0 to LONG_AW.
    function automatic logic [LONG_AW-1:0] low_mask(input logic [M_W-1:0] n);
        logic [LONG_AW:0] ones;
        ones = ({{LONG_AW{1'b0}}, 1'b1} << n) - 1'b1;
        return ones[LONG_AW-1:0];
    endfunction

endpackage

// ===== design/ophist_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ophist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ophist_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on ophist_pkg for the command type and queue depth.

module ophist_queue import ophist_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   cmd_in,
    input  logic   pop,
    output cmd_t   cmd_out,
    output qstat_t stat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign cmd_out    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/ophist_front.sv =====
`timescale 1ns / 1ps
// Front part: takes items and configuration, tracks the bit history and turns
// each item into a command for the back part. Depends on ophist_pkg.

module ophist_front import ophist_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic              bit_value,
    input  logic              last_bit,
    input  logic              table_select,
    input  logic [IDX_W-1:0]  pattern_index,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [M_W-1:0]    cfg_data,
    input  stall_t            stall,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic [M_W-1:0]      block_length_reg, block_length_next;
    logic [SHORT_AW-1:0] head_reg, head_next;
    logic [SHORT_AW-1:0] recent_reg, recent_next;
    logic [SEQ_W-1:0]    bits_seen_reg, bits_seen_next;
    logic                done_reg, done_next;

    logic                accept;
    logic [M_W-1:0]      m_eff;
    logic [M_W:0]        m_plus1;
    logic [LONG_AW-1:0]  mask_long;
    logic [SHORT_AW-1:0] mask_short;
    logic                new_seq;
    logic [SEQ_W-1:0]    base_seen;
    logic [SHORT_AW-1:0] base_recent;
    logic [SHORT_AW-1:0] base_head;
    logic                active;
    logic [SHORT_AW-1:0] shifted_recent;

    assign busy      = stall.q_full | stall.clearing;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign q_push    = accept;

    assign m_eff      = (block_length_reg > M_MAX) ? M_MAX : block_length_reg;
    assign m_plus1    = {1'b0, m_eff} + 1'b1;
    assign mask_long  = low_mask(m_eff);
    assign mask_short = mask_long[SHORT_AW-1:0];

    // The first bit of a new sequence starts from cleared history.
    assign new_seq        = (bits_seen_reg == '0) || done_reg;
    assign base_seen      = new_seq ? '0 : bits_seen_reg;
    assign base_recent    = new_seq ? '0 : recent_reg;
    assign base_head      = new_seq ? '0 : head_reg;
    assign active         = (base_seen < SEQ_LIMIT);
    assign shifted_recent = {base_recent[SHORT_AW-2:0], bit_value};

    always_comb
    begin
        q_cmd           = '0;
        q_cmd.kind      = op_t'(operation);
        q_cmd.m         = m_eff;
        q_cmd.rd_table  = table_select;
        q_cmd.rd_idx    = pattern_index;
        q_cmd.rd_ok     = table_select ? ((pattern_index >> m_plus1) == '0)
                                       : ((pattern_index >> m_eff) == '0);
        q_cmd.done      = done_reg;
        q_cmd.clear_req = new_seq;
        q_cmd.long_en   = active && (base_seen >= SEQ_W'(m_eff));
        q_cmd.long_idx  = {base_recent & mask_short, bit_value};
        q_cmd.short_en  = active && (({1'b0, base_seen} + 1'b1) >= (SEQ_W + 1)'(m_eff));
        q_cmd.short_idx = (active ? shifted_recent : base_recent) & mask_short;
        q_cmd.wrap_en   = last_bit;
        q_cmd.recent    = active ? shifted_recent : base_recent;
        q_cmd.head      = (active && (base_seen < SEQ_W'(m_eff)))
                          ? {base_head[SHORT_AW-2:0], bit_value} : base_head;
    end

    always_comb
    begin
        block_length_next = block_length_reg;
        head_next         = head_reg;
        recent_next       = recent_reg;
        bits_seen_next    = bits_seen_reg;
        done_next         = done_reg;
        if (cfg_valid && cfg_ready)
        begin
            block_length_next = cfg_data;
        end
        if (accept && (op_t'(operation) == OP_PUSH))
        begin
            head_next      = q_cmd.head;
            recent_next    = q_cmd.recent;
            bits_seen_next = active ? base_seen + 1'b1 : base_seen;
            done_next      = last_bit ? 1'b1 : (new_seq ? 1'b0 : done_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RESET;
            head_reg         <= '0;
            recent_reg       <= '0;
            bits_seen_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            block_length_reg <= block_length_next;
            head_reg         <= head_next;
            recent_reg       <= recent_next;
            bits_seen_reg    <= bits_seen_next;
            done_reg         <= done_next;
        end
    end

endmodule

// ===== design/ophist_back.sv =====
`timescale 1ns / 1ps
// Back part: executes commands on the two count tables (clearing sweep,
// read-modify-write increments, wrap windows, count reads). Depends on
// ophist_pkg and ophist_ram.

module ophist_back import ophist_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               q_cmd,
    input  qstat_t             qstat,
    output logic               q_pop,
    output logic               clearing,
    output logic               result_valid,
    output logic [COUNT_W-1:0] pattern_count,
    output logic               sequence_complete
);

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [LONG_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [M_W-1:0]      t_reg, t_next;
    logic                tables_zero_reg, tables_zero_next;
    logic                resume_reg, resume_next;
    logic                result_valid_reg, result_valid_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                complete_reg, complete_next;

    logic                long_we, short_we;
    logic [LONG_AW-1:0]  long_addr;
    logic [SHORT_AW-1:0] short_addr;
    logic [COUNT_W-1:0]  long_wdata, short_wdata;
    logic [COUNT_W-1:0]  long_rdata, short_rdata;

    logic [LONG_AW-1:0]  head_m, recent_l, front_bits;
    logic [LONG_AW-1:0]  wrap_long, wrap_short_full;
    logic [SHORT_AW-1:0] wrap_short;

    ophist_ram #(.WIDTH(COUNT_W), .DEPTH(LONG_DEPTH)) u_long_ram (
        .clk   (clk),
        .we    (long_we),
        .waddr (long_addr),
        .wdata (long_wdata),
        .raddr (long_addr),
        .rdata (long_rdata)
    );

    ophist_ram #(.WIDTH(COUNT_W), .DEPTH(SHORT_DEPTH)) u_short_ram (
        .clk   (clk),
        .we    (short_we),
        .waddr (short_addr),
        .wdata (short_wdata),
        .raddr (short_addr),
        .rdata (short_rdata)
    );

    // Wrap window t joins the low bits of the tail with the top t head bits.
    assign head_m          = {1'b0, cmd_reg.head} & low_mask(cmd_reg.m);
    assign recent_l        = {1'b0, cmd_reg.recent};
    assign front_bits      = head_m >> (cmd_reg.m - t_reg);
    assign wrap_long       = ((recent_l & low_mask(M_W'(cmd_reg.m + M_W'(1) - t_reg))) << t_reg)
                             | front_bits;
    assign wrap_short_full = ((recent_l & low_mask(M_W'(cmd_reg.m - t_reg))) << t_reg)
                             | front_bits;
    assign wrap_short      = wrap_short_full[SHORT_AW-1:0];

    assign clearing          = (state_reg == ST_CLEAR);
    assign result_valid      = result_valid_reg;
    assign pattern_count     = count_reg;
    assign sequence_complete = complete_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    if (q_cmd.kind == OP_READ)
                    begin
                        state_next = ST_READ_RD;
                    end
                    else if (q_cmd.clear_req && !tables_zero_reg)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_BUMP_RD;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLEAR_LAST)
                begin
                    state_next = resume_reg ? ST_BUMP_RD : ST_IDLE;
                end
            end
            ST_BUMP_RD:  state_next = ST_BUMP_WR;
            ST_BUMP_WR:
            begin
                state_next = (cmd_reg.wrap_en && (cmd_reg.m != '0)) ? ST_WRAP_RD : ST_IDLE;
            end
            ST_WRAP_RD:  state_next = ST_WRAP_WR;
            ST_WRAP_WR:  state_next = (t_reg == cmd_reg.m) ? ST_IDLE : ST_WRAP_RD;
            ST_READ_RD:  state_next = ST_READ_OUT;
            ST_READ_OUT: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        cmd_next          = cmd_reg;
        clr_addr_next     = clr_addr_reg;
        t_next            = t_reg;
        tables_zero_next  = tables_zero_reg;
        resume_next       = resume_reg;
        result_valid_next = 1'b0;
        count_next        = count_reg;
        complete_next     = complete_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    cmd_next      = q_cmd;
                    clr_addr_next = '0;
                    resume_next   = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLEAR_LAST)
                begin
                    tables_zero_next = 1'b1;
                end
            end
            ST_BUMP_WR:
            begin
                tables_zero_next = 1'b0;
                t_next           = M_W'(1);
            end
            ST_WRAP_WR:
            begin
                t_next = t_reg + 1'b1;
            end
            ST_READ_OUT:
            begin
                result_valid_next = 1'b1;
                complete_next     = cmd_reg.done;
                if (!cmd_reg.rd_ok)
                begin
                    count_next = '0;
                end
                else
                begin
                    count_next = cmd_reg.rd_table ? long_rdata : short_rdata;
                end
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    // Table ports and queue pop.
    always_comb
    begin
        q_pop       = (state_reg == ST_IDLE) && !qstat.empty;
        long_we     = 1'b0;
        short_we    = 1'b0;
        long_addr   = '0;
        short_addr  = '0;
        long_wdata  = long_rdata + 1'b1;
        short_wdata = short_rdata + 1'b1;
        if (state_reg inside {ST_WRAP_RD, ST_WRAP_WR})
        begin
            long_addr  = wrap_long;
            short_addr = wrap_short;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                long_addr   = clr_addr_reg;
                short_addr  = clr_addr_reg[SHORT_AW-1:0];
                long_we     = 1'b1;
                short_we    = 1'b1;
                long_wdata  = '0;
                short_wdata = '0;
            end
            ST_BUMP_RD:
            begin
                long_addr  = cmd_reg.long_idx;
                short_addr = cmd_reg.short_idx;
            end
            ST_BUMP_WR:
            begin
                long_addr  = cmd_reg.long_idx;
                short_addr = cmd_reg.short_idx;
                long_we    = cmd_reg.long_en && (long_rdata != COUNT_LIMIT);
                short_we   = cmd_reg.short_en && (short_rdata != COUNT_LIMIT);
            end
            ST_WRAP_WR:
            begin
                long_we  = (long_rdata != COUNT_LIMIT);
                short_we = (t_reg < cmd_reg.m) && (short_rdata != COUNT_LIMIT);
            end
            ST_READ_RD, ST_READ_OUT:
            begin
                long_addr  = cmd_reg.rd_idx[LONG_AW-1:0];
                short_addr = cmd_reg.rd_idx[SHORT_AW-1:0];
            end
            default:
            begin
                long_we  = 1'b0;
                short_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        count_reg    <= count_next;
        complete_reg <= complete_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            t_reg            <= '0;
            tables_zero_reg  <= 1'b0;
            resume_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            t_reg            <= t_next;
            tables_zero_reg  <= tables_zero_next;
            resume_reg       <= resume_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for more than one cycle");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUMP_WR) |-> $past(state_reg == ST_BUMP_RD))
        else $error("increment written without a preceding table read");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("command taken from an empty queue");

    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRAP_RD) || (state_reg == ST_WRAP_WR))
        |-> ((t_reg != '0) && (t_reg <= cmd_reg.m)))
        else $error("wrap window step out of range");

endmodule

// ===== design/overlapping_pattern_histogram_unit.sv =====
`timescale 1ns / 1ps
// Top level of the overlapping pattern histogram unit: front part, command
// queue and back part. Depends on ophist_pkg, ophist_front, ophist_queue, ophist_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------------
//   item in  | start / busy              | operation, bit_value, last_bit,
//            |                           | table_select, pattern_index
//   result   | result_valid (strobe)     | pattern_count, sequence_complete
//   config   | cfg_valid / cfg_ready     | cfg_data (block_length)
//
// A push beat runs through a table read and a table write state, plus a read and
// write state pair per wrap window on the last bit; a read runs through a table
// read and an output state, and its strobe comes in the cycle after the output state.
// The read-modify-write on the count tables, one address per table, sets these steps.
// After reset, and on the first bit of a sequence when the tables hold counts,
// a clearing sweep over all 2048 long-table addresses runs with busy high.
// Two commands queue between front and back; busy rises when the queue is full.
// Results are never held off: each strobe lasts one cycle.

module overlapping_pattern_histogram_unit import ophist_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic               bit_value,
    input  logic               last_bit,
    input  logic               table_select,
    input  logic [IDX_W-1:0]   pattern_index,
    output logic               result_valid,
    output logic [COUNT_W-1:0] pattern_count,
    output logic               sequence_complete,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [M_W-1:0]     cfg_data
);

    logic   q_push, q_pop, clearing;
    cmd_t   q_cmd_in, q_cmd_out;
    qstat_t qstat;
    stall_t stall;

    assign stall.q_full   = qstat.full;
    assign stall.clearing = clearing;

    ophist_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .bit_value     (bit_value),
        .last_bit      (last_bit),
        .table_select  (table_select),
        .pattern_index (pattern_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .stall         (stall),
        .q_push        (q_push),
        .q_cmd         (q_cmd_in)
    );

    ophist_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .pop     (q_pop),
        .cmd_out (q_cmd_out),
        .stat    (qstat)
    );

    ophist_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_cmd             (q_cmd_out),
        .qstat             (qstat),
        .q_pop             (q_pop),
        .clearing          (clearing),
        .result_valid      (result_valid),
        .pattern_count     (pattern_count),
        .sequence_complete (sequence_complete)
    );

endmodule

// ===== tb/pattern_count_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the overlapping pattern histogram unit: keeps its own copy of the
// pattern count tables, follows every accepted beat and compares each result beat.
// Depends on ophist_pkg.

module pattern_count_checker import ophist_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               operation,
    input  logic               bit_value,
    input  logic               last_bit,
    input  logic               table_select,
    input  logic [IDX_W-1:0]   pattern_index,
    input  logic               result_valid,
    input  logic [COUNT_W-1:0] pattern_count,
    input  logic               sequence_complete,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [M_W-1:0]     cfg_data,
    output int                 failures,
    output int                 outstanding
);

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               complete;
    } count_reply_t;

    count_reply_t        expected_counts[$];

    logic [M_W-1:0]      block_len;
    logic [SHORT_AW-1:0] head_bits;
    logic [SHORT_AW-1:0] recent_bits;
    int unsigned         bits_seen;
    logic                seq_done;
    logic [COUNT_W-1:0]  short_counts [SHORT_DEPTH];
    logic [COUNT_W-1:0]  long_counts [LONG_DEPTH];
    int                  fail_count = 0;

    function automatic int unsigned ones_below(input int unsigned n);
        return (32'd1 << n) - 32'd1;
    endfunction

    // Register values above the maximum block length act as the maximum.
    function automatic int unsigned pattern_len();
        return (block_len > M_MAX) ? MAX_BLOCK_LENGTH : int'(block_len);
    endfunction

    task automatic tally_short(input int unsigned idx);
        if (idx < SHORT_DEPTH && short_counts[idx] != COUNT_LIMIT)
        begin
            short_counts[idx] = short_counts[idx] + 1'b1;
        end
    endtask

    task automatic tally_long(input int unsigned idx);
        if (idx < LONG_DEPTH && long_counts[idx] != COUNT_LIMIT)
        begin
            long_counts[idx] = long_counts[idx] + 1'b1;
        end
    endtask

    task automatic clear_histogram();
        for (int i = 0; i < SHORT_DEPTH; i++)
        begin
            short_counts[i] = '0;
        end
        for (int i = 0; i < LONG_DEPTH; i++)
        begin
            long_counts[i] = '0;
        end
        head_bits   = '0;
        recent_bits = '0;
        bits_seen   = 0;
        seq_done    = 1'b0;
    endtask

    task automatic advance_histogram(input logic b, input logic last);
        int unsigned m;
        int unsigned old_recent;
        int unsigned head;
        int unsigned front;
        int unsigned t;
        m = pattern_len();
        // The first bit of a new sequence wipes everything from the previous one.
        if (bits_seen == 0 || seq_done)
        begin
            clear_histogram();
        end
        if (bits_seen < MAX_SEQUENCE_LENGTH)
        begin
            old_recent = recent_bits;
            if (bits_seen >= m)
            begin
                tally_long(((old_recent & ones_below(m)) << 1) | b);
            end
            recent_bits = {recent_bits[SHORT_AW-2:0], b};
            if (bits_seen + 1 >= m)
            begin
                tally_short(recent_bits & ones_below(m));
            end
            if (bits_seen < m)
            begin
                head_bits = {head_bits[SHORT_AW-2:0], b};
            end
            bits_seen++;
        end
        // Wrap windows join the tail of the sequence with its first m bits.
        if (last)
        begin
            head = head_bits & ones_below(m);
            for (t = 1; t <= m; t++)
            begin
                front = head >> (m - t);
                tally_long(((recent_bits & ones_below(m + 1 - t)) << t) | front);
                if (t < m)
                begin
                    tally_short(((recent_bits & ones_below(m - t)) << t) | front);
                end
            end
            seq_done = 1'b1;
        end
    endtask

    function automatic count_reply_t lookup_count(input logic sel,
                                                  input logic [IDX_W-1:0] idx);
        count_reply_t reply;
        int unsigned  m;
        m = pattern_len();
        reply.count    = '0;
        reply.complete = seq_done;
        if (!sel)
        begin
            if (idx < (32'd1 << m))
            begin
                reply.count = short_counts[idx[SHORT_AW-1:0]];
            end
        end
        else if (idx < (32'd1 << (m + 1)))
        begin
            reply.count = long_counts[idx[LONG_AW-1:0]];
        end
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        count_reply_t want;
        if (!rst_n)
        begin
            block_len = BLOCK_LENGTH_RESET;
            clear_histogram();
            expected_counts.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_counts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected result beat: count %0d complete %0b",
                                 pattern_count, sequence_complete);
                    end
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (pattern_count !== want.count || sequence_complete !== want.complete)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result mismatch: expected count %0d complete %0b, %s",
                                     want.count, want.complete, "see actual below");
                            $display("                 actual   count %0d complete %0b",
                                     pattern_count, sequence_complete);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                block_len = cfg_data;
            end
            if (start && !busy)
            begin
                if (operation == OP_READ)
                begin
                    expected_counts.push_back(lookup_count(table_select, pattern_index));
                end
                else
                begin
                    advance_histogram(bit_value, last_bit);
                end
            end
        end
        outstanding <= expected_counts.size();
        failures    <= fail_count;
    end

endmodule

// ===== tb/overlapping_pattern_histogram_unit_tb.sv =====
`timescale 1ns / 1ps
// Top of the overlapping pattern histogram unit testbench: clock, reset, item and
// register stimulus, and the verdict. Depends on ophist_pkg, the unit and pattern_count_checker.

module overlapping_pattern_histogram_unit_tb import ophist_pkg::*; ();

    localparam int RANDOM_ITEMS  = 1350;
    // A clearing sweep plus the slowest push with its wrap windows.
    localparam int SETTLE_CYCLES = 2048 + 64;
    localparam int DRAIN_LIMIT   = 20000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               operation;
    logic               bit_value;
    logic               last_bit;
    logic               table_select;
    logic [IDX_W-1:0]   pattern_index;
    logic               result_valid;
    logic [COUNT_W-1:0] pattern_count;
    logic               sequence_complete;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [M_W-1:0]     cfg_data;

    int                 failures;
    int                 outstanding;
    int                 idle_pct;
    int                 items_sent;

    overlapping_pattern_histogram_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .bit_value         (bit_value),
        .last_bit          (last_bit),
        .table_select      (table_select),
        .pattern_index     (pattern_index),
        .result_valid      (result_valid),
        .pattern_count     (pattern_count),
        .sequence_complete (sequence_complete),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    pattern_count_checker count_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .bit_value         (bit_value),
        .last_bit          (last_bit),
        .table_select      (table_select),
        .pattern_index     (pattern_index),
        .result_valid      (result_valid),
        .pattern_count     (pattern_count),
        .sequence_complete (sequence_complete),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .failures          (failures),
        .outstanding       (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input op_t op, input logic b, input logic last,
                             input logic sel, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        operation     <= op;
        bit_value     <= b;
        last_bit      <= last;
        table_select  <= sel;
        pattern_index <= idx;
        start         <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic push_bit(input logic b, input logic last);
        send_item(OP_PUSH, b, last, 1'($urandom_range(1)), IDX_W'($urandom_range(2047)));
    endtask

    task automatic read_count(input logic sel, input logic [IDX_W-1:0] idx);
        send_item(OP_READ, 1'($urandom_range(1)), 1'($urandom_range(1)), sel, idx);
    endtask

    // Mostly indexes inside the selected table, now and then anything at all.
    function automatic logic [IDX_W-1:0] pick_index(input logic sel, input int m);
        if ($urandom_range(7) == 0)
        begin
            return IDX_W'($urandom_range(2047));
        end
        return IDX_W'($urandom_range((1 << (m + sel)) - 1));
    endfunction

    // Write a new pattern length only once all work is finished; the block does not check it.
    task automatic write_block_length(input logic [M_W-1:0] value);
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_sequence(input int m);
        int   kind;
        int   style;
        int   len;
        int   reads;
        logic b;
        kind  = $urandom_range(9);
        style = $urandom_range(3);
        if (kind == 0)
        begin
            // Too short to fill one long window unless the block length is zero.
            len = (m == 0) ? 1 : $urandom_range(1, m);
        end
        else
        begin
            len = m + 1 + $urandom_range(0, 30);
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                read_count(1'($urandom_range(1)), pick_index(1'($urandom_range(1)), m));
            end
            case (style)
                0: b = 1'($urandom_range(1));
                1: b = 1'b0;
                2: b = 1'b1;
                default: b = (i % 3 == 0);
            endcase
            // A broken sequence never marks its last bit and runs on into the next one.
            push_bit(b, (kind != 1) && (i == len - 1));
        end
        reads = $urandom_range(3, 10);
        for (int i = 0; i < reads; i++)
        begin
            b = 1'($urandom_range(1));
            read_count(b, pick_index(b, m));
        end
    endtask

    initial
    begin
        int          phase;
        int          m;
        int          wait_cycles;
        logic [3:0]  len_value;
        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = OP_PUSH;
        bit_value     = 1'b0;
        last_bit      = 1'b0;
        table_select  = 1'b0;
        pattern_index = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        idle_pct      = 13;
        items_sent    = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Tables are empty and no sequence is complete after reset.
        read_count(1'b0, IDX_W'(0));
        read_count(1'b1, IDX_W'(2047));

        write_block_length(4'd2);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            read_count(1'b0, IDX_W'(i));
        end
        for (int i = 0; i < 8; i++)
        begin
            read_count(1'b1, IDX_W'(i));
        end

        // With a zero block length the short table has the single empty pattern.
        write_block_length(4'd0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b1);
        read_count(1'b0, IDX_W'(0));
        read_count(1'b0, IDX_W'(1));
        read_count(1'b1, IDX_W'(1));

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: len_value = 4'd15;
                1: len_value = 4'd0;
                2: len_value = 4'd1;
                3: len_value = 4'd10;
                4: len_value = 4'd11;
                default: len_value = 4'($urandom_range(15));
            endcase
            write_block_length(len_value);
            m = (len_value > M_MAX) ? MAX_BLOCK_LENGTH : int'(len_value);
            for (int s = $urandom_range(1, 3); s > 0; s--)
            begin
                if (items_sent < RANDOM_ITEMS / 3)
                begin
                    idle_pct = 13;
                end
                else if (items_sent < 2 * RANDOM_ITEMS / 3)
                begin
                    idle_pct = 79;
                end
                else
                begin
                    idle_pct = 0;
                end
                run_sequence(m);
            end
            phase++;
        end

        start <= 1'b0;
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (64) @(negedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
